// ===== sv/fblik_pkg.sv =====
// ----------------------------------------------------------------------------
// fblik_pkg
// Shared types, constants and the arctangent table for the five-bar leg
// inverse kinematics unit.
// ----------------------------------------------------------------------------
package fblik_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_LEN          = 24;
    localparam int ATAN_IDXW         = 5;

    // CORDIC vector width and angle width (radians Q.24)
    localparam int CW = 44;
    localparam int AW = 32;

    // divider / square root operand width and result width
    localparam int DENW = 34;
    localparam int QW   = 15;

    localparam logic signed [AW-1:0] PI_Q24      = 32'sd52707179;
    localparam logic signed [AW-1:0] HALF_PI_Q24 = 32'sd26353589;
    localparam logic signed [AW-1:0] TWO_PI_Q24  = 32'sd105414358;
    localparam logic [29:0]          GAIN_INV_Q30 = 30'd652032874;

    typedef logic signed [CW-1:0] t_cvec;
    typedef logic signed [AW-1:0] t_angle;

    typedef struct packed {
        logic   start;
        logic   vec;    // 1: vectoring (atan2), 0: rotation
        t_cvec  x;
        t_cvec  y;
        t_angle z;
    } t_cordic_req;

    typedef struct packed {
        logic   done;
        t_cvec  x;
        t_cvec  y;
        t_angle z;
    } t_cordic_rsp;

    typedef struct packed {
        logic            start;
        logic            is_sqrt;
        logic [DENW-1:0] num;
        logic [DENW-1:0] den;
    } t_ds_req;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] res;
    } t_ds_rsp;

    function automatic t_angle atan_q24(input logic [ATAN_IDXW-1:0] idx);
        t_angle v;
        case (idx)
            5'd0:  v = 32'sd13176795;
            5'd1:  v = 32'sd7778716;
            5'd2:  v = 32'sd4110060;
            5'd3:  v = 32'sd2086331;
            5'd4:  v = 32'sd1047214;
            5'd5:  v = 32'sd524117;
            5'd6:  v = 32'sd262123;
            5'd7:  v = 32'sd131069;
            5'd8:  v = 32'sd65536;
            5'd9:  v = 32'sd32768;
            5'd10: v = 32'sd16384;
            5'd11: v = 32'sd8192;
            5'd12: v = 32'sd4096;
            5'd13: v = 32'sd2048;
            5'd14: v = 32'sd1024;
            5'd15: v = 32'sd512;
            5'd16: v = 32'sd256;
            5'd17: v = 32'sd128;
            5'd18: v = 32'sd64;
            5'd19: v = 32'sd32;
            5'd20: v = 32'sd16;
            5'd21: v = 32'sd8;
            5'd22: v = 32'sd4;
            5'd23: v = 32'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/fblik_divsqrt.sv =====
// ----------------------------------------------------------------------------
// fblik_divsqrt
// Shared restoring divider (cosine ratio) and bit-serial square root (sine),
// one result bit per cycle over one subtractor.
// ----------------------------------------------------------------------------
module fblik_divsqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fblik_pkg::t_ds_req i_req,
    output fblik_pkg::t_ds_rsp o_rsp
);

    localparam int WW    = fblik_pkg::DENW + 2;
    localparam int RW    = 30;
    localparam int BW    = 29;
    localparam int STEPS = fblik_pkg::QW;
    localparam int CNTW  = $clog2(STEPS);

    logic            r_busy;
    logic            r_done;
    logic            r_sqrt;
    logic [CNTW-1:0] r_cnt;
    logic [WW-1:0]   r_a;
    logic [WW-1:0]   r_d;
    logic [RW-1:0]   r_res;
    logic [BW-1:0]   r_bit;

    logic [WW-1:0]   w_sub;
    logic [WW:0]     w_diff;
    logic            w_ge;

    assign w_sub  = r_sqrt ? (WW'(r_res) + WW'(r_bit)) : r_d;
    assign w_diff = {1'b0, r_a} - {1'b0, w_sub};
    assign w_ge   = ~w_diff[WW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                end
            end else begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            if (i_req.start) begin
                r_sqrt <= i_req.is_sqrt;
                r_a    <= WW'(i_req.num);
                r_d    <= WW'(i_req.den);
                r_res  <= '0;
                r_bit  <= BW'(1) << (BW - 1);
            end
        end else if (r_sqrt) begin
            if (w_ge) begin
                r_a   <= w_diff[WW-1:0];
                r_res <= (r_res >> 1) + RW'(r_bit);
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end else begin
            if (w_ge) begin
                r_a   <= {w_diff[WW-2:0], 1'b0};
                r_res <= {r_res[RW-2:0], 1'b1};
            end else begin
                r_a   <= {r_a[WW-2:0], 1'b0};
                r_res <= {r_res[RW-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res[fblik_pkg::QW-1:0];

endmodule

// ===== sv/fblik_cordic.sv =====
// ----------------------------------------------------------------------------
// fblik_cordic
// Shared CORDIC: vectoring mode for atan2 (with normalizing pre-shift and
// half-plane pre-rotation) and rotation mode (with angle wrap and fold).
// ----------------------------------------------------------------------------
module fblik_cordic #(
    parameter int ITERATIONS = fblik_pkg::CORDIC_ITERATIONS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fblik_pkg::t_cordic_req i_req,
    output fblik_pkg::t_cordic_rsp o_rsp
);

    localparam int CW = fblik_pkg::CW;
    localparam int AW = fblik_pkg::AW;
    localparam int IW = $clog2(ITERATIONS);
    localparam int TW = fblik_pkg::ATAN_IDXW;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_NORM = 2'd1;
    localparam logic [1:0] C_WRAP = 2'd2;
    localparam logic [1:0] C_ITER = 2'd3;

    localparam logic signed [CW-1:0] NORM_HI = CW'(64'sh80_0000_0000);
    localparam logic signed [CW-1:0] NORM_LO = CW'(64'sh8000_0000);

    logic [1:0]       r_state;
    logic             r_done;
    logic             r_vec;
    logic [IW-1:0]    r_i;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [AW-1:0] r_z;

    logic signed [CW-1:0] w_ax;
    logic signed [CW-1:0] w_ay;
    logic signed [CW-1:0] w_m;
    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    logic signed [AW-1:0] w_atan;
    logic                 w_dir;

    assign w_ax   = r_x[CW-1] ? -r_x : r_x;
    assign w_ay   = r_y[CW-1] ? -r_y : r_y;
    assign w_m    = (w_ax > w_ay) ? w_ax : w_ay;
    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = fblik_pkg::atan_q24(TW'(r_i));
    // direction: drive y toward zero (vectoring) or angle toward zero (rotation)
    assign w_dir  = r_vec ? ~r_y[CW-1] : r_z[AW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_i     <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_i <= '0;
                        if (!i_req.vec) begin
                            r_state <= C_WRAP;
                        end else if (i_req.x == '0 && i_req.y == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= C_NORM;
                        end
                    end
                end
                C_NORM: begin
                    if (w_m >= NORM_HI) begin
                        r_state <= C_ITER;
                    end
                end
                C_WRAP: begin
                    if (r_z <= fblik_pkg::PI_Q24 && r_z > -fblik_pkg::PI_Q24) begin
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == IW'(ITERATIONS - 1)) begin
                        r_state <= C_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                if (i_req.start) begin
                    r_vec <= i_req.vec;
                    r_x   <= i_req.x;
                    r_y   <= i_req.y;
                    r_z   <= i_req.vec ? '0 : i_req.z;
                end
            end
            C_NORM: begin
                if (w_m >= NORM_HI) begin
                    // left half plane: rotate by pi first
                    if (r_x[CW-1]) begin
                        r_x <= -r_x;
                        r_y <= -r_y;
                        r_z <= r_y[CW-1] ? -fblik_pkg::PI_Q24 : fblik_pkg::PI_Q24;
                    end
                end else if (w_m < NORM_LO) begin
                    r_x <= r_x <<< 8;
                    r_y <= r_y <<< 8;
                end else begin
                    r_x <= r_x <<< 1;
                    r_y <= r_y <<< 1;
                end
            end
            C_WRAP: begin
                if (r_z > fblik_pkg::PI_Q24) begin
                    r_z <= r_z - fblik_pkg::TWO_PI_Q24;
                end else if (r_z <= -fblik_pkg::PI_Q24) begin
                    r_z <= r_z + fblik_pkg::TWO_PI_Q24;
                end else if (r_z > fblik_pkg::HALF_PI_Q24) begin
                    r_z <= r_z - fblik_pkg::PI_Q24;
                    r_x <= -r_x;
                end else if (r_z < -fblik_pkg::HALF_PI_Q24) begin
                    r_z <= r_z + fblik_pkg::PI_Q24;
                    r_x <= -r_x;
                end
            end
            default: begin
                if (w_dir) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_atan;
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_atan;
                end
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = r_x;
    assign o_rsp.y    = r_y;
    assign o_rsp.z    = r_z;

endmodule

// ===== sv/five_bar_leg_inverse_kinematics_unit.sv =====
// ----------------------------------------------------------------------------
// five_bar_leg_inverse_kinematics_unit
// Thigh and shank joint angles of a two-servo five-bar leg from a foot pose.
// ----------------------------------------------------------------------------
// Usage:
//  - Config port: i_cfg_wr_en/i_cfg_index/i_cfg_wdata write one link length or
//    pivot offset per cycle (index 0..6, other indexes ignored). Write only
//    while the unit is idle.
//  - Input channel (i_in_valid/o_in_ready): one word carries action, target_x
//    and target_z. Action 0 loads the stored pose, action 1 adds a step to it
//    with saturation to 24 bits.
//  - Output channel (o_out_valid/i_out_ready): one word per input word with
//    both angles (Q4.12) and the unreachable flag (angles zero when set).
//  - Sequencing: for each word the sequencer walks the shared CORDIC (five
//    atan2 plus one rotation, each a normalize or wrap phase and
//    CORDIC_ITERATIONS steps), the shared divider/square root (four
//    operations per word) and the shared multiplier.
//    An unreachable knee or coupler triangle ends the word early.
//  - Throughput: one word at a time; o_in_ready is high only when idle.
//  - The result sits in an output register; a new word is accepted while it
//    waits. If the receiver stalls, the next result holds in the final state
//    until the register frees.
//  - Reset (synchronous, active low) clears config registers, pose and state.
// ----------------------------------------------------------------------------
module five_bar_leg_inverse_kinematics_unit #(
    parameter int CORDIC_ITERATIONS = fblik_pkg::CORDIC_ITERATIONS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_wdata,
    // input words
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic signed [23:0] i_target_x,
    input  logic signed [23:0] i_target_z,
    // result words
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_thigh_angle,
    output logic signed [15:0] o_shank_angle,
    output logic               o_unreachable
);

    localparam int CW   = fblik_pkg::CW;
    localparam int AW   = fblik_pkg::AW;
    localparam int DENW = fblik_pkg::DENW;
    localparam int QW   = fblik_pkg::QW;
    localparam int NW   = 56;  // triangle numerator
    localparam int DW   = 27;  // pivot-relative coordinates

    localparam logic [2:0] REG_L1 = 3'd0;
    localparam logic [2:0] REG_L5 = 3'd1;
    localparam logic [2:0] REG_L2 = 3'd2;
    localparam logic [2:0] REG_L3 = 3'd3;
    localparam logic [2:0] REG_L4 = 3'd4;
    localparam logic [2:0] REG_PX = 3'd5;
    localparam logic [2:0] REG_PZ = 3'd6;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_SQ_A = 5'd1;
    localparam logic [4:0] ST_SQ_B = 5'd2;
    localparam logic [4:0] ST_SQ_X = 5'd3;
    localparam logic [4:0] ST_SQ_Z = 5'd4;
    localparam logic [4:0] ST_DEN  = 5'd5;
    localparam logic [4:0] ST_ABS  = 5'd6;
    localparam logic [4:0] ST_CHK  = 5'd7;
    localparam logic [4:0] ST_DIVW = 5'd8;
    localparam logic [4:0] ST_CC   = 5'd9;
    localparam logic [4:0] ST_SQ0  = 5'd10;
    localparam logic [4:0] ST_SQW  = 5'd11;
    localparam logic [4:0] ST_MS   = 5'd12;
    localparam logic [4:0] ST_MC   = 5'd13;
    localparam logic [4:0] ST_AX   = 5'd14;
    localparam logic [4:0] ST_AT0  = 5'd15;
    localparam logic [4:0] ST_AT0W = 5'd16;
    localparam logic [4:0] ST_AT1W = 5'd17;
    localparam logic [4:0] ST_AT2W = 5'd18;
    localparam logic [4:0] ST_RG   = 5'd19;
    localparam logic [4:0] ST_ROT  = 5'd20;
    localparam logic [4:0] ST_ROTW = 5'd21;
    localparam logic [4:0] ST_DXZ  = 5'd22;
    localparam logic [4:0] ST_FIN  = 5'd23;

    // configuration
    logic [15:0]        r_l1, r_l5, r_l2, r_l3, r_l4;
    logic signed [15:0] r_px, r_pz;

    // control
    logic [4:0] r_state, n_state;
    logic       r_ph;       // 0: knee triangle, 1: coupler triangle
    logic       r_unr;
    logic       r_unr_out;
    logic       r_out_valid;

    // pose and datapath
    logic signed [23:0]   r_pose_x, r_pose_z;
    logic signed [63:0]   r_prod;
    logic signed [NW-1:0] r_num;
    logic [DENW-1:0]      r_den;
    logic                 r_neg;
    logic signed [15:0]   r_c;
    logic [QW-1:0]        r_s;
    logic signed [CW-1:0] r_ay, r_ax;
    logic signed [AW-1:0] r_acc, r_rad0, r_rad1, r_th4;
    logic signed [DW-1:0] r_rc, r_rs, r_dx, r_dz;
    logic signed [15:0]   r_thigh, r_shank;

    // shared units
    fblik_pkg::t_cordic_req w_creq;
    fblik_pkg::t_cordic_rsp w_crsp;
    fblik_pkg::t_ds_req     w_dreq;
    fblik_pkg::t_ds_rsp     w_drsp;

    logic signed [31:0] w_ma, w_mb;
    logic [15:0]        w_la, w_lb;
    logic signed [DW-1:0] w_px, w_pz;
    logic               w_in_acc;
    logic               w_out_load;
    logic signed [24:0] w_sum_x, w_sum_z;
    logic signed [63:0] w_rad_sum;

    fblik_cordic #(
        .ITERATIONS(CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_creq),
        .o_rsp  (w_crsp)
    );

    fblik_divsqrt u_divsqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    function automatic logic signed [15:0] to_q412(input logic signed [AW-1:0] a);
        logic signed [AW:0] v;
        v = ((AW+1)'(a) + (AW+1)'(2048)) >>> 12;
        if (v > (AW+1)'(32767)) begin
            return 16'sh7FFF;
        end else if (v < -(AW+1)'(32768)) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // triangle operands: knee uses L1/L5 and the pose, coupler L2/L3 and dx/dz
    assign w_la = r_ph ? r_l2 : r_l1;
    assign w_lb = r_ph ? r_l3 : r_l5;
    assign w_px = r_ph ? r_dx : DW'(r_pose_x);
    assign w_pz = r_ph ? r_dz : DW'(r_pose_z);

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);
    assign w_sum_x    = 25'(r_pose_x) + 25'(i_target_x);
    assign w_sum_z    = 25'(r_pose_z) + 25'(i_target_z);
    assign w_rad_sum  = 64'(r_acc) + 64'(w_crsp.z);

    // shared multiplier operands
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ST_SQ_A: begin w_ma = 32'(w_la); w_mb = 32'(w_la); end
            ST_SQ_B: begin w_ma = 32'(w_lb); w_mb = 32'(w_lb); end
            ST_SQ_X: begin w_ma = 32'(w_px); w_mb = 32'(w_px); end
            ST_SQ_Z: begin w_ma = 32'(w_pz); w_mb = 32'(w_pz); end
            ST_DEN:  begin w_ma = 32'(w_la); w_mb = 32'(w_lb); end
            ST_CC:   begin w_ma = 32'(r_c);  w_mb = 32'(r_c);  end
            ST_MS:   begin w_ma = 32'(w_lb); w_mb = 32'(r_s);  end
            ST_MC:   begin w_ma = 32'(w_lb); w_mb = 32'(r_c);  end
            ST_RG: begin
                w_ma = 32'(17'(r_l4) + 17'(r_l5));
                w_mb = 32'(fblik_pkg::GAIN_INV_Q30);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // requests to the shared units
    always_comb begin
        w_creq       = '0;
        w_creq.vec   = 1'b1;
        w_dreq       = '0;
        case (r_state)
            ST_AT0: begin
                w_creq.start = 1'b1;
                if (r_ph) begin
                    w_creq.x = CW'(r_dx);
                    w_creq.y = CW'(r_dz);
                end else begin
                    w_creq.x = -CW'(r_pose_x);
                    w_creq.y = CW'(r_pose_z);
                end
            end
            ST_AT0W: begin
                w_creq.start = w_crsp.done;
                w_creq.x     = r_ax;
                w_creq.y     = r_ay;
            end
            ST_AT1W: begin
                w_creq.start = w_crsp.done && !r_ph;
                w_creq.x     = CW'(r_c);
                w_creq.y     = CW'(r_s);
            end
            ST_ROT: begin
                w_creq.start = 1'b1;
                w_creq.vec   = 1'b0;
                w_creq.x     = CW'(r_prod >>> 14);
                w_creq.z     = r_th4;
            end
            ST_CHK: begin
                w_dreq.start = (r_den != '0) && (r_num <= NW'(r_den));
                w_dreq.num   = r_num[DENW-1:0];
                w_dreq.den   = r_den;
            end
            ST_SQ0: begin
                w_dreq.start   = 1'b1;
                w_dreq.is_sqrt = 1'b1;
                w_dreq.num     = DENW'(29'h1000_0000 - r_prod[28:0]);
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_SQ_A;
            ST_SQ_A: n_state = ST_SQ_B;
            ST_SQ_B: n_state = ST_SQ_X;
            ST_SQ_X: n_state = ST_SQ_Z;
            ST_SQ_Z: n_state = ST_DEN;
            ST_DEN:  n_state = ST_ABS;
            ST_ABS:  n_state = ST_CHK;
            ST_CHK:  n_state = w_dreq.start ? ST_DIVW : ST_FIN;
            ST_DIVW: if (w_drsp.done) n_state = ST_CC;
            ST_CC:   n_state = ST_SQ0;
            ST_SQ0:  n_state = ST_SQW;
            ST_SQW:  if (w_drsp.done) n_state = ST_MS;
            ST_MS:   n_state = ST_MC;
            ST_MC:   n_state = ST_AX;
            ST_AX:   n_state = ST_AT0;
            ST_AT0:  n_state = ST_AT0W;
            ST_AT0W: if (w_crsp.done) n_state = ST_AT1W;
            ST_AT1W: if (w_crsp.done) n_state = r_ph ? ST_FIN : ST_AT2W;
            ST_AT2W: if (w_crsp.done) n_state = ST_RG;
            ST_RG:   n_state = ST_ROT;
            ST_ROT:  n_state = ST_ROTW;
            ST_ROTW: if (w_crsp.done) n_state = ST_DXZ;
            ST_DXZ:  n_state = ST_SQ_A;
            ST_FIN:  if (w_out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_ph        <= 1'b0;
            r_unr       <= 1'b0;
            r_pose_x    <= '0;
            r_pose_z    <= '0;
            r_l1        <= '0;
            r_l5        <= '0;
            r_l2        <= '0;
            r_l3        <= '0;
            r_l4        <= '0;
            r_px        <= '0;
            r_pz        <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_L1:  r_l1 <= i_cfg_wdata;
                    REG_L5:  r_l5 <= i_cfg_wdata;
                    REG_L2:  r_l2 <= i_cfg_wdata;
                    REG_L3:  r_l3 <= i_cfg_wdata;
                    REG_L4:  r_l4 <= i_cfg_wdata;
                    REG_PX:  r_px <= i_cfg_wdata;
                    REG_PZ:  r_pz <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (w_in_acc) begin
                r_ph  <= 1'b0;
                r_unr <= 1'b0;
                if (i_action) begin
                    // saturate the stepped pose to 24 bits
                    if (w_sum_x[24] != w_sum_x[23])
                        r_pose_x <= w_sum_x[24] ? 24'sh800000 : 24'sh7FFFFF;
                    else
                        r_pose_x <= w_sum_x[23:0];
                    if (w_sum_z[24] != w_sum_z[23])
                        r_pose_z <= w_sum_z[24] ? 24'sh800000 : 24'sh7FFFFF;
                    else
                        r_pose_z <= w_sum_z[23:0];
                end else begin
                    r_pose_x <= i_target_x;
                    r_pose_z <= i_target_z;
                end
            end

            if (r_state == ST_CHK && !w_dreq.start) r_unr <= 1'b1;
            if (r_state == ST_DXZ) r_ph <= 1'b1;

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_SQ_B: r_num <= NW'(r_prod);
            ST_SQ_X: r_num <= r_num + NW'(r_prod);
            ST_SQ_Z: r_num <= r_num - NW'(r_prod);
            ST_DEN:  r_num <= r_num - NW'(r_prod);
            ST_ABS: begin
                r_den <= {r_prod[DENW-2:0], 1'b0};
                r_neg <= r_num[NW-1];
                r_num <= r_num[NW-1] ? -r_num : r_num;
            end
            ST_DIVW: begin
                if (w_drsp.done)
                    r_c <= r_neg ? -16'(w_drsp.res) : 16'(w_drsp.res);
            end
            ST_SQW: if (w_drsp.done) r_s <= w_drsp.res;
            ST_MC:  r_ay <= CW'(r_prod);
            ST_AX:  r_ax <= CW'($signed({34'd0, w_la, 14'd0}) - r_prod);
            ST_AT0W: if (w_crsp.done) r_acc <= w_crsp.z;
            ST_AT1W: begin
                if (w_crsp.done) begin
                    if (r_ph) r_rad1 <= AW'(w_rad_sum);
                    else      r_rad0 <= AW'(w_rad_sum);
                end
            end
            ST_AT2W: if (w_crsp.done) r_th4 <= w_crsp.z + r_rad0;
            ST_ROTW: begin
                if (w_crsp.done) begin
                    r_rc <= DW'((w_crsp.x + CW'(32768)) >>> 16);
                    r_rs <= DW'((w_crsp.y + CW'(32768)) >>> 16);
                end
            end
            ST_DXZ: begin
                r_dx <= r_rc - DW'(r_pose_x) - DW'(r_px);
                r_dz <= r_rs + DW'(r_pose_z) - DW'(r_pz);
            end
            default: ;
        endcase

        if (w_out_load) begin
            r_thigh <= r_unr ? 16'sd0 : to_q412(r_rad0);
            r_shank <= r_unr ? 16'sd0 : to_q412(r_rad1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) r_unr_out <= r_unr;
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_thigh_angle = r_thigh;
    assign o_shank_angle = r_shank;
    assign o_unreachable = r_unr_out;

endmodule
